// File: hdl/ngsv_pkg.sv
// Package for the NMEA GSV receive monitor: word types, character codes and match patterns.
`default_nettype none

package ngsv_pkg;

   // Default for the longest line, counting the dropped LF.
   localparam int LINE_CHARS_DEFAULT = 110;

   // Input word: one received character or a power-down clear.
   typedef struct packed {
      logic       cmd;
      logic [7:0] rx_byte;
   } req_type;

   // Result word.
   typedef struct packed {
      logic [7:0] sats_in_view;
      logic [7:0] best_snr;
      logic [2:0] vendor;
      logic       line_done;
      logic       gsv_taken;
   } rsp_type;

   // Command codes.
   localparam logic CMD_BYTE       = 1'b0;
   localparam logic CMD_POWER_DOWN = 1'b1;

   // Vendor codes.
   localparam logic [2:0] VENDOR_UNKNOWN = 3'd0;
   localparam logic [2:0] VENDOR_BANNER  = 3'd1;
   localparam logic [2:0] VENDOR_PMTK    = 3'd2;
   localparam logic [2:0] VENDOR_PQTM    = 3'd3;
   localparam logic [2:0] VENDOR_PSRF    = 3'd4;

   // Character codes.
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_VT     = 8'h0B;
   localparam logic [7:0] CHAR_FF     = 8'h0C;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   // Banner patterns, oldest character in the top byte.
   localparam logic [47:0] BANNER_A = 48'h752D626C6F78;
   localparam logic [63:0] BANNER_B = 64'h524F4D20434F5245;
   localparam logic [55:0] BANNER_C = 56'h50524F54564552;
   localparam logic [39:0] BANNER_D = 40'h75626C6F78;

   // Numbers saturate here.
   localparam logic [13:0] VALUE_MAX = 14'd9999;

endpackage

`default_nettype wire

// File: hdl/nmea_gsv_receive_monitor_core.sv
// Top level of the NMEA GSV receive monitor: input register, line tracker and result register.
// A result word passes from the input register, through the line tracker, into the result
// register, which holds it until it is taken.
// Throughput: one word per cycle while the output is not stalled; the tracker steps per word.
// Reset: synchronous and active high; clears the valid flags of both pipeline registers, the
// line state, the held values and the vendor code.
`default_nettype none

module nmea_gsv_receive_monitor_core
   import ngsv_pkg::*;
#(
   parameter int LINE_CHARS = LINE_CHARS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   // The input register holds one word. It is handed to the line tracker in the cycle in
   // which the result register can take the outcome, so the tracker state and the result
   // register always move together.
   logic    in_valid_ff, in_valid_in;
   req_type in_word_ff, in_word_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_word_ff, out_word_in;
   rsp_type tracker_result;
   logic    advance;
   logic    fire;

   // The pipeline moves whenever the result register is empty or its word is being taken.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   ngsv_line_tracker #(
      .LINE_CHARS(LINE_CHARS)
   ) u_tracker (
      .clock (clock),
      .reset (reset),
      .step  (fire),
      .item  (in_word_ff),
      .result(tracker_result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_word_in   = in_word_ff;
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      // The input register takes a new word when it is empty or its word moves on.
      if (!in_valid_ff || advance) begin
         in_valid_in = req_valid;
         in_word_in  = req_data;
      end
      if (advance) begin
         out_valid_in = in_valid_ff;
         out_word_in  = tracker_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_word_ff  <= in_word_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

endmodule

`default_nettype wire

// File: hdl/ngsv_line_tracker.sv
// Line state of the monitor: field scanning, number reading, line judging and held values.
`default_nettype none

module ngsv_line_tracker
   import ngsv_pkg::*;
#(
   parameter int LINE_CHARS = LINE_CHARS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  wire req_type item,
   output rsp_type      result
);

   localparam int CNT_W = $clog2(LINE_CHARS);
   localparam logic [CNT_W-1:0] KEEP_LIMIT = CNT_W'(LINE_CHARS - 1);

   typedef struct packed {
      logic [13:0] acc;
      logic        neg;
      logic        closed;
      logic        started;
   } num_type;

   typedef struct packed {
      logic [7:0] in_view;
      logic [7:0] best;
   } pend_type;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [47:0]      head_ff, head_in;
   logic [CNT_W-1:0] fnum_ff, fnum_in;
   logic             nonempty_ff, nonempty_in;
   logic             stopped_ff, stopped_in;
   logic             at_start_ff, at_start_in;
   logic             text_ended_ff, text_ended_in;
   num_type          num_ff, num_in;
   pend_type         pend_ff, pend_in;
   logic [63:0]      window_ff, window_in;
   logic             banner_ff, banner_in;
   logic [7:0]       held_view_ff, held_view_in;
   logic [7:0]       held_best_ff, held_best_in;
   logic [2:0]       vendor_ff, vendor_in;
   logic             done, taken;
   logic [7:0]       c;
   logic             is_txt, is_ver;

   function automatic num_type feed_number(num_type n, logic [7:0] ch);
      num_type     r;
      logic [16:0] prod;
      r    = n;
      prod = ({3'b0, n.acc} << 3) + ({3'b0, n.acc} << 1) + {13'b0, ch[3:0]};
      if (!n.closed) begin
         if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            r.acc     = (prod > {3'b0, VALUE_MAX}) ? VALUE_MAX : prod[13:0];
            r.started = 1'b1;
         end else if (!n.started && (ch == CHAR_SPACE || ch == CHAR_TAB ||
                                     ch == CHAR_VT || ch == CHAR_FF)) begin
            r = n;
         end else if (!n.started && (ch == CHAR_PLUS || ch == CHAR_MINUS)) begin
            r.neg     = (ch == CHAR_MINUS);
            r.started = 1'b1;
         end else begin
            r.closed = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic pend_type commit_field(pend_type p, logic nonempty,
                                             logic [CNT_W-1:0] fnum, num_type n);
      pend_type r;
      r = p;
      if (nonempty) begin
         if (9'(fnum) == 9'd4) begin
            r.in_view = n.neg ? 8'(14'd0 - n.acc) : n.acc[7:0];
         end else if (9'(fnum) >= 9'd8 && fnum[1:0] == 2'b00) begin
            if (!n.neg && n.acc > {6'b0, p.best}) begin
               r.best = n.acc[7:0];
            end
         end
      end
      return r;
   endfunction

   assign c      = item.rx_byte;
   assign is_txt = head_ff[31:24] == "T" && head_ff[39:32] == "X" && head_ff[47:40] == "T";
   assign is_ver = head_ff[31:24] == "V" && head_ff[39:32] == "E" && head_ff[47:40] == "R";

   always_comb begin
      cnt_in        = cnt_ff;
      head_in       = head_ff;
      fnum_in       = fnum_ff;
      nonempty_in   = nonempty_ff;
      stopped_in    = stopped_ff;
      at_start_in   = at_start_ff;
      text_ended_in = text_ended_ff;
      num_in        = num_ff;
      pend_in       = pend_ff;
      window_in     = window_ff;
      banner_in     = banner_ff;
      held_view_in  = held_view_ff;
      held_best_in  = held_best_ff;
      vendor_in     = vendor_ff;
      done          = 1'b0;
      taken         = 1'b0;

      if (step) begin
         if (item.cmd == CMD_POWER_DOWN || c == CHAR_LF) begin
            if (item.cmd == CMD_POWER_DOWN) begin
               held_view_in = 8'd0;
               held_best_in = 8'd0;
            end else begin
               if (!stopped_ff && !at_start_ff) begin
                  pend_in = commit_field(pend_ff, nonempty_ff, fnum_ff, num_ff);
               end
               if (cnt_ff > CNT_W'(6) && head_ff[7:0] == CHAR_DOLLAR) begin
                  done = 1'b1;
                  if (head_ff[31:24] == "G" && head_ff[39:32] == "S" &&
                      head_ff[47:40] == "V") begin
                     held_view_in = pend_in.in_view;
                     held_best_in = pend_in.best;
                     taken        = 1'b1;
                  end else begin
                     if ((is_txt || is_ver) && banner_ff) begin
                        vendor_in = VENDOR_BANNER;
                     end
                     if (head_ff[15:8] == "P") begin
                        priority if (head_ff[23:16] == "M" && head_ff[31:24] == "T" &&
                                     head_ff[39:32] == "K") begin
                           vendor_in = VENDOR_PMTK;
                        end else if (head_ff[23:16] == "Q" && head_ff[31:24] == "T" &&
                                     head_ff[39:32] == "M") begin
                           vendor_in = VENDOR_PQTM;
                        end else if (head_ff[23:16] == "S" && head_ff[31:24] == "R" &&
                                     head_ff[39:32] == "F") begin
                           vendor_in = VENDOR_PSRF;
                        end else begin
                           vendor_in = vendor_in;
                        end
                     end
                  end
               end
            end
            // Both the power-down and the end of a line start a fresh line.
            cnt_in        = '0;
            head_in       = '0;
            fnum_in       = '0;
            nonempty_in   = 1'b0;
            stopped_in    = 1'b0;
            at_start_in   = 1'b1;
            text_ended_in = 1'b0;
            num_in        = '0;
            pend_in       = '0;
            window_in     = '0;
            banner_in     = 1'b0;
         end else if (c != CHAR_CR && cnt_ff < KEEP_LIMIT) begin
            for (int p = 0; p < 6; p++) begin
               if (cnt_ff == CNT_W'(p)) begin
                  head_in[8*p +: 8] = c;
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (!text_ended_ff) begin
               if (c == CHAR_NUL) begin
                  // A NUL ends the text: the open field is closed and nothing more is scanned.
                  text_ended_in = 1'b1;
                  if (!stopped_ff && !at_start_ff) begin
                     pend_in     = commit_field(pend_ff, nonempty_ff, fnum_ff, num_ff);
                     num_in      = '0;
                     nonempty_in = 1'b0;
                  end
                  stopped_in = 1'b1;
               end else begin
                  window_in = {window_ff[55:0], c};
                  if (window_in[47:0] == BANNER_A || window_in == BANNER_B ||
                      window_in[55:0] == BANNER_C || window_in[39:0] == BANNER_D) begin
                     banner_in = 1'b1;
                  end
                  if (!stopped_ff) begin
                     if (at_start_ff) begin
                        if (c == CHAR_STAR) begin
                           stopped_in = 1'b1;
                        end else begin
                           fnum_in     = fnum_ff + 1'b1;
                           at_start_in = 1'b0;
                           if (c == CHAR_COMMA) begin
                              // An empty field leaves the gathered values alone.
                              nonempty_in = 1'b0;
                              num_in      = '0;
                              at_start_in = 1'b1;
                           end else begin
                              nonempty_in = 1'b1;
                              num_in      = feed_number(num_ff, c);
                           end
                        end
                     end else if (c == CHAR_COMMA) begin
                        pend_in     = commit_field(pend_ff, nonempty_ff, fnum_ff, num_ff);
                        num_in      = '0;
                        nonempty_in = 1'b0;
                        at_start_in = 1'b1;
                     end else begin
                        num_in = feed_number(num_ff, c);
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         head_ff       <= '0;
         fnum_ff       <= '0;
         nonempty_ff   <= 1'b0;
         stopped_ff    <= 1'b0;
         at_start_ff   <= 1'b1;
         text_ended_ff <= 1'b0;
         num_ff        <= '0;
         pend_ff       <= '0;
         window_ff     <= '0;
         banner_ff     <= 1'b0;
         held_view_ff  <= 8'd0;
         held_best_ff  <= 8'd0;
         vendor_ff     <= VENDOR_UNKNOWN;
      end else begin
         cnt_ff        <= cnt_in;
         head_ff       <= head_in;
         fnum_ff       <= fnum_in;
         nonempty_ff   <= nonempty_in;
         stopped_ff    <= stopped_in;
         at_start_ff   <= at_start_in;
         text_ended_ff <= text_ended_in;
         num_ff        <= num_in;
         pend_ff       <= pend_in;
         window_ff     <= window_in;
         banner_ff     <= banner_in;
         held_view_ff  <= held_view_in;
         held_best_ff  <= held_best_in;
         vendor_ff     <= vendor_in;
      end
   end

   assign result.sats_in_view = held_view_in;
   assign result.best_snr     = held_best_in;
   assign result.vendor       = vendor_in;
   assign result.line_done    = done;
   assign result.gsv_taken    = taken;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the NMEA GSV receive monitor: directed sentences, then random traffic.
`timescale 1ns / 1ps

module tb_top;
   import ngsv_pkg::*;

   // Longest kept line: the block keeps one character fewer than its line length.
   localparam int MAX_KEPT = LINE_CHARS_DEFAULT - 1;
   // Input words to send in total before the run winds down.
   localparam int WORD_TARGET = 1550;

   // Sentence types and proprietary prefixes, first character in the top byte.
   localparam logic [23:0] TYPE_GSV  = "GSV";
   localparam logic [23:0] TYPE_TXT  = "TXT";
   localparam logic [23:0] TYPE_VER  = "VER";
   localparam logic [23:0] PROP_MTK  = "MTK";
   localparam logic [23:0] PROP_QTM  = "QTM";
   localparam logic [23:0] PROP_SRF  = "SRF";
   localparam logic [7:0]  CHAR_P    = "P";

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   nmea_gsv_receive_monitor_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The run is ended here if the block stops moving words. The slowest legal run is a few
   // milliseconds, so this leaves a wide margin.
   initial begin
      #15_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // ------------------------------------------------------------------------------------------
   // Line tracker model. It keeps its own copy of the line state and of the values shown at
   // the outputs, and works out the result word that each accepted input word must produce.
   // ------------------------------------------------------------------------------------------

   int unsigned kept_len;       // characters kept from the current line
   logic [47:0] head_text;      // first six kept characters, the first in the low byte
   int unsigned field_no;       // fields begun so far; the '$' word is field one
   bit          field_filled;   // the current field started with something other than a comma
   bit          scan_stopped;   // no more fields are read on this line
   bit          at_field_edge;  // the next kept character opens a field
   int unsigned num_mag;        // magnitude of the number being read, held at the maximum
   bit          num_minus;
   bit          num_begun;      // a sign or a digit has been read
   bit          num_closed;     // the number has ended; the rest of the field is ignored
   bit          nul_kept;       // a NUL was kept, which ends all scanning of the line
   logic [7:0]  line_view;      // values gathered from the current line
   logic [7:0]  line_best;
   logic [63:0] last_eight;     // last eight kept characters, the newest in the low byte
   bit          chip_banner;    // a chip-name substring has been seen on this line
   logic [7:0]  shown_view;     // values on the outputs
   logic [7:0]  shown_best;
   logic [2:0]  shown_vendor;

   // Coverage tallies for the closing summary.
   int          words_sent;
   int          lines_judged;
   int          gsv_commits;
   int          clears_sent;
   logic [7:0]  vendors_reached;

   function automatic void forget_line();
      kept_len      = 0;
      head_text     = '0;
      field_no      = 0;
      field_filled  = 1'b0;
      scan_stopped  = 1'b0;
      at_field_edge = 1'b1;
      num_mag       = 0;
      num_minus     = 1'b0;
      num_begun     = 1'b0;
      num_closed    = 1'b0;
      nul_kept      = 1'b0;
      line_view     = '0;
      line_best     = '0;
      last_eight    = '0;
      chip_banner   = 1'b0;
   endfunction

   // Reads numbers the way atoi does: leading blanks, one sign, then digits up to the first
   // character that is not a digit.
   function automatic void read_number_char(logic [7:0] c);
      if (num_closed) return;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         num_mag = num_mag * 10 + 32'(c - CHAR_ZERO);
         if (num_mag > VALUE_MAX) num_mag = VALUE_MAX;
         num_begun = 1'b1;
      end else if (!num_begun && (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT ||
                                  c == CHAR_FF)) begin
         // Leading blanks are passed over.
      end else if (!num_begun && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
         num_minus = (c == CHAR_MINUS);
         num_begun = 1'b1;
      end else begin
         num_closed = 1'b1;
      end
   endfunction

   // At the end of a field the in-view count takes the low byte of the signed value, and each
   // SNR field replaces the best value only when its full value is larger than the stored byte.
   function automatic void close_field();
      logic [31:0] signed_val;
      if (field_filled) begin
         if (field_no == 4) begin
            signed_val = num_minus ? (32'd0 - num_mag) : num_mag;
            line_view  = signed_val[7:0];
         end else if (field_no >= 8 && field_no % 4 == 0) begin
            if (!num_minus && num_mag > line_best) line_best = num_mag[7:0];
         end
      end
      num_mag      = 0;
      num_minus    = 1'b0;
      num_begun    = 1'b0;
      num_closed   = 1'b0;
      field_filled = 1'b0;
   endfunction

   function automatic void keep_char(logic [7:0] c);
      if (kept_len < 6) head_text[8 * kept_len +: 8] = c;
      kept_len++;
      if (nul_kept) return;
      if (c == CHAR_NUL) begin
         // The NUL stays in the head text, but nothing after it is scanned.
         nul_kept = 1'b1;
         if (!scan_stopped && !at_field_edge) close_field();
         scan_stopped = 1'b1;
         return;
      end
      last_eight = {last_eight[55:0], c};
      if (last_eight[47:0] == BANNER_A || last_eight == BANNER_B ||
          last_eight[55:0] == BANNER_C || last_eight[39:0] == BANNER_D)
         chip_banner = 1'b1;
      if (scan_stopped) return;
      if (at_field_edge) begin
         // A field that opens with the checksum star ends the scan.
         if (c == CHAR_STAR) begin
            scan_stopped = 1'b1;
            return;
         end
         field_no++;
         at_field_edge = 1'b0;
         field_filled  = (c != CHAR_COMMA);
         if (c == CHAR_COMMA) begin
            close_field();
            at_field_edge = 1'b1;
            return;
         end
         read_number_char(c);
      end else if (c == CHAR_COMMA) begin
         close_field();
         at_field_edge = 1'b1;
      end else begin
         read_number_char(c);
      end
   endfunction

   function automatic rsp_type predict_report(req_type w);
      rsp_type     r;
      logic [23:0] kind_text;
      logic [23:0] prop_text;
      r = '0;
      if (w.cmd == CMD_POWER_DOWN) begin
         // Power-down clears the held counts and the line, but the vendor code survives.
         shown_view = '0;
         shown_best = '0;
         forget_line();
         clears_sent++;
      end else if (w.rx_byte == CHAR_LF) begin
         if (!scan_stopped && !at_field_edge) close_field();
         if (kept_len > 6 && head_text[7:0] == CHAR_DOLLAR) begin
            kind_text   = {head_text[31:24], head_text[39:32], head_text[47:40]};
            prop_text   = {head_text[23:16], head_text[31:24], head_text[39:32]};
            r.line_done = 1'b1;
            lines_judged++;
            if (kind_text == TYPE_GSV) begin
               shown_view  = line_view;
               shown_best  = line_best;
               r.gsv_taken = 1'b1;
               gsv_commits++;
            end else begin
               if ((kind_text == TYPE_TXT || kind_text == TYPE_VER) && chip_banner)
                  shown_vendor = VENDOR_BANNER;
               if (head_text[15:8] == CHAR_P) begin
                  if (prop_text == PROP_MTK) shown_vendor = VENDOR_PMTK;
                  else if (prop_text == PROP_QTM) shown_vendor = VENDOR_PQTM;
                  else if (prop_text == PROP_SRF) shown_vendor = VENDOR_PSRF;
               end
            end
         end
         forget_line();
      end else if (w.rx_byte != CHAR_CR && kept_len < MAX_KEPT) begin
         keep_char(w.rx_byte);
      end
      vendors_reached[shown_vendor] = 1'b1;
      r.sats_in_view = shown_view;
      r.best_snr     = shown_best;
      r.vendor       = shown_vendor;
      return r;
   endfunction

   // ------------------------------------------------------------------------------------------
   // Handshakes. Both sides leave gaps of random length: mostly none or short, now and then
   // long. While calm_stretch is set neither side idles, so back-to-back words are exercised.
   // ------------------------------------------------------------------------------------------

   bit      calm_stretch = 1'b0;
   rsp_type awaited_reports[$];
   rsp_type want_report;
   int      stall_left = 0;
   int      failures   = 0;

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm_stretch || roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   // Valid is left high after a word is taken, so that a following word with no gap goes out
   // on the very next cycle. It is lowered only when a gap begins.
   task automatic send_word(req_type w);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      awaited_reports.push_back(predict_report(w));
      words_sent++;
   endtask

   task automatic send_char(logic [7:0] c);
      req_type w;
      w.cmd     = CMD_BYTE;
      w.rx_byte = c;
      send_word(w);
   endtask

   // A power-down word carries a random byte, which the block must ignore.
   task automatic send_power_down();
      req_type w;
      w.cmd     = CMD_POWER_DOWN;
      w.rx_byte = 8'($urandom_range(0, 255));
      send_word(w);
   endtask

   // Result side: each accepted word is checked against the oldest expectation, and the stall
   // for the next cycle is chosen afterwards so that the value tested is the one at the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_reports.size() == 0) begin
            $error("result word %h arrived with no word awaited", rsp_data);
            failures++;
         end else begin
            want_report = awaited_reports.pop_front();
            if (rsp_data.sats_in_view !== want_report.sats_in_view) begin
               $error("sats_in_view: expected %0d, actual %0d", want_report.sats_in_view,
                      rsp_data.sats_in_view);
               failures++;
            end
            if (rsp_data.best_snr !== want_report.best_snr) begin
               $error("best_snr: expected %0d, actual %0d", want_report.best_snr,
                      rsp_data.best_snr);
               failures++;
            end
            if (rsp_data.vendor !== want_report.vendor) begin
               $error("vendor: expected %0d, actual %0d", want_report.vendor, rsp_data.vendor);
               failures++;
            end
            if (rsp_data.line_done !== want_report.line_done) begin
               $error("line_done: expected %0b, actual %0b", want_report.line_done,
                      rsp_data.line_done);
               failures++;
            end
            if (rsp_data.gsv_taken !== want_report.gsv_taken) begin
               $error("gsv_taken: expected %0b, actual %0b", want_report.gsv_taken,
                      rsp_data.gsv_taken);
               failures++;
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = pick_gap();
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // ------------------------------------------------------------------------------------------
   // Sentence building. A line is assembled as characters in line_buf, then sent one word at a
   // time. Building a line never touches the model; only sending does.
   // ------------------------------------------------------------------------------------------

   logic [7:0] line_buf[$];
   string      hex_digits   = "0123456789ABCDEF";
   string      talker_chars = "GPLNBDQ";

   function automatic void put_byte(logic [7:0] c);
      line_buf.push_back(c);
   endfunction

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endfunction

   function automatic void put_digits(int n);
      repeat (n) put_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
   endfunction

   function automatic void put_hex_pair();
      put_byte(hex_digits[$urandom_range(0, 15)]);
      put_byte(hex_digits[$urandom_range(0, 15)]);
   endfunction

   function automatic void put_talker();
      put_byte(talker_chars[$urandom_range(0, talker_chars.len() - 1)]);
      put_byte(talker_chars[$urandom_range(0, talker_chars.len() - 1)]);
   endfunction

   // Puts the first n characters of a banner constant, oldest character first.
   function automatic void put_banner_chars(logic [63:0] chars, int n);
      for (int k = n - 1; k >= 0; k--) put_byte(chars[8 * k +: 8]);
   endfunction

   function automatic void put_any_banner();
      case ($urandom_range(0, 3))
         0:       put_banner_chars(64'(BANNER_A), 6);
         1:       put_banner_chars(BANNER_B, 8);
         2:       put_banner_chars(64'(BANNER_C), 7);
         default: put_banner_chars(64'(BANNER_D), 5);
      endcase
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 3))
         0:       return CHAR_SPACE;
         1:       return CHAR_TAB;
         2:       return CHAR_VT;
         default: return CHAR_FF;
      endcase
   endfunction

   // A numeric field in one of several shapes: empty, plain, with blanks or a sign, long
   // enough to saturate, cut short by a stray character, or with a doubled sign.
   function automatic void put_number_field();
      logic [7:0] stray;
      stray = 8'($urandom_range(0, 255));
      if (stray == CHAR_LF) stray = CHAR_STAR;
      case ($urandom_range(0, 9))
         0: ;
         1: begin
            repeat ($urandom_range(1, 3)) put_byte(pick_blank());
            put_digits($urandom_range(1, 3));
         end
         2: begin
            put_byte($urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS);
            put_digits($urandom_range(1, 3));
         end
         3: put_digits($urandom_range(5, 7));
         4: begin
            put_digits($urandom_range(1, 2));
            put_byte(stray);
            put_digits(1);
         end
         5: begin
            put_byte(CHAR_MINUS);
            put_byte(CHAR_MINUS);
            put_digits(2);
         end
         default: put_digits($urandom_range(1, 3));
      endcase
   endfunction

   function automatic void put_line_end();
      if ($urandom_range(0, 9) < 7) begin
         put_byte(CHAR_STAR);
         put_hex_pair();
      end
      if ($urandom_range(0, 3) != 0) put_byte(CHAR_CR);
      put_byte(CHAR_LF);
   endfunction

   function automatic void build_gsv_line();
      put_byte(CHAR_DOLLAR);
      put_talker();
      put_text("GSV,");
      put_digits(1);
      put_text(",");
      put_digits(1);
      put_text(",");
      put_number_field();
      repeat ($urandom_range(0, 4)) begin
         put_text(",");
         put_digits($urandom_range(0, 2));
         put_text(",");
         put_digits($urandom_range(0, 2));
         put_text(",");
         put_digits($urandom_range(0, 3));
         put_text(",");
         put_number_field();
      end
      put_line_end();
      // Now and then a NUL lands somewhere in the sentence.
      if ($urandom_range(0, 19) == 0)
         line_buf.insert($urandom_range(1, line_buf.size() - 2), CHAR_NUL);
   endfunction

   function automatic void build_banner_line();
      put_byte(CHAR_DOLLAR);
      put_talker();
      put_text($urandom_range(0, 1) ? "TXT" : "VER");
      put_text(",01,01,02,");
      repeat ($urandom_range(0, 4)) put_byte("A" + 8'($urandom_range(0, 25)));
      if ($urandom_range(0, 9) < 7) put_any_banner();
      repeat ($urandom_range(0, 4)) put_byte("a" + 8'($urandom_range(0, 25)));
      put_line_end();
   endfunction

   function automatic void build_proprietary_line();
      put_text("$P");
      case ($urandom_range(0, 3))
         0: put_text("MTK");
         1: put_text("QTM");
         2: put_text("SRF");
         default: begin
            put_byte("A" + 8'($urandom_range(0, 25)));
            put_byte("A" + 8'($urandom_range(0, 25)));
            put_byte("A" + 8'($urandom_range(0, 25)));
         end
      endcase
      put_digits($urandom_range(0, 3));
      repeat ($urandom_range(0, 3)) begin
         put_text(",");
         put_digits($urandom_range(0, 3));
      end
      put_line_end();
   endfunction

   // Another sentence type, which must be judged but leave every held value alone, even when
   // a banner substring sits inside it.
   function automatic void build_other_line();
      put_byte(CHAR_DOLLAR);
      put_talker();
      put_text($urandom_range(0, 1) ? "GGA," : "RMC,");
      put_digits($urandom_range(0, 6));
      put_text(",");
      if ($urandom_range(0, 1)) put_any_banner();
      put_text(",");
      put_number_field();
      put_line_end();
   endfunction

   function automatic void build_noise_line();
      logic [7:0] c;
      repeat ($urandom_range(1, 20)) begin
         c = 8'($urandom_range(0, 255));
         put_byte(c);
      end
      if ($urandom_range(0, 1)) put_byte(CHAR_LF);
   endfunction

   function automatic void build_overlong_line();
      int reach;
      reach = $urandom_range(MAX_KEPT + 1, MAX_KEPT + 30);
      put_text("$GPGSV,1,1,");
      put_digits(2);
      while (line_buf.size() < reach) begin
         put_text(",");
         put_digits(2);
         put_text(",");
         put_number_field();
      end
      put_byte(CHAR_LF);
   endfunction

   task automatic send_line();
      while (line_buf.size() > 0) send_char(line_buf.pop_front());
   endtask

   // ------------------------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------------------------

   // Power-down with both extreme bytes beside it, bare line ends, and the extreme characters
   // outside any sentence.
   task automatic test_power_down_and_extremes();
      req_type w;
      w.cmd     = CMD_POWER_DOWN;
      w.rx_byte = 8'hFF;
      send_word(w);
      w.rx_byte = 8'h00;
      send_word(w);
      send_char(CHAR_LF);
      send_char(8'hFF);
      send_char(CHAR_NUL);
      send_char(CHAR_CR);
      send_char(CHAR_LF);
   endtask

   // GSV sentences: a typical one, one with blanks, signs, saturation and a star inside the
   // last field, one whose in-view count wraps and whose SNR is negative, one where a field
   // opens with the star, and one cut by power-down.
   task automatic test_gsv_fields();
      calm_stretch = 1'b1;
      put_text("$GPGSV,3,1,11,07,79,048,42,02,51,062,43,09,12,,28*7A\r\n");
      send_line();
      put_text("$GPGSV,1,1,");
      put_byte(CHAR_TAB);
      put_text("-3,a,b,c,");
      put_byte(CHAR_SPACE);
      put_byte(CHAR_VT);
      put_byte(CHAR_FF);
      put_text("300,,,,12345,,,,+45*1F\r\n");
      send_line();
      calm_stretch = 1'b0;
      put_text("$GLGSV,1,1,300,1,2,3,-40,1,2,3,7*00\n");
      send_line();
      put_text("$GPGSV,1,1,*5,1,2,3,60\n");
      send_line();
      put_text("$GPGSV,1,1,12,01,40,083,46");
      send_line();
      send_power_down();
      send_char(CHAR_LF);
   endtask

   // Chip-name banners in TXT and VER lines, the three proprietary prefixes, a TXT line with
   // no banner and a banner in a line of another type.
   task automatic test_banner_and_vendor();
      put_text("$GPTXT,01,01,02,");
      put_banner_chars(64'(BANNER_A), 6);
      put_text(" 6M*5A\r\n");
      put_text("$PMTK011,MTKGPS*08\r\n");
      put_text("$GNVER,");
      put_banner_chars(BANNER_B, 8);
      put_text("\r\n");
      put_text("$PQTMVER,1*00\r\n");
      put_text("$GPTXT,");
      put_banner_chars(64'(BANNER_C), 7);
      put_text("=14\r\n");
      put_text("$PSRF156,1*00\r\n");
      put_text("$GPTXT,01,01,02,ANTENNA OK*35\r\n");
      put_text("$GPVER,");
      put_banner_chars(64'(BANNER_D), 5);
      put_text("\n");
      put_text("$PMTK\n");
      send_line();
      send_power_down();
      put_text("$GPGGA,");
      put_banner_chars(64'(BANNER_D), 5);
      put_text(",1\n");
      send_line();
   endtask

   // Lines too short to judge, a line without the dollar, NUL inside the fields and inside the
   // sentence type, and a top-bit character inside a number.
   task automatic test_short_lines_and_nul();
      put_text("$GPGSV\n$GPGSV,\nGPGSV,1,1,05,1,2,3,40\n$GPGSV,1,1,");
      send_line();
      send_char(CHAR_NUL);
      put_text("5,1,2,3,44\n$GPGSV,1,1,09,1,2,3,3");
      send_line();
      send_char(CHAR_NUL);
      put_text("9\n$G");
      send_line();
      send_char(CHAR_NUL);
      put_text("GSV,1,1,07\n$GPGSV,1,1,2");
      send_line();
      send_char(8'h80);
      put_text("4,1,2,3,99\n");
      send_line();
   endtask

   // A GSV line that fills the kept length exactly, with two larger SNR groups after it that must
   // be dropped.
   task automatic test_overlong_line();
      put_text("$GPGSV,1,1,07");
      repeat (8) put_text(",01,02,03,50");
      put_text(",01,02,03,90,01,02,03,95\r\n");
      send_line();
   endtask

   // Mostly well-formed sentences with random content, mixed with broken ones, line noise and
   // stray power-downs.
   task automatic test_random_traffic();
      int cut;
      while (words_sent < WORD_TARGET) begin
         if ($urandom_range(0, 9) == 0) calm_stretch = !calm_stretch;
         case ($urandom_range(0, 99)) inside
            [0:44]:  build_gsv_line();
            [45:56]: build_banner_line();
            [57:66]: build_proprietary_line();
            [67:74]: build_other_line();
            [75:83]: build_noise_line();
            [84:86]: build_overlong_line();
            default: begin
               build_gsv_line();
               cut = $urandom_range(1, line_buf.size() - 1);
               while (line_buf.size() > cut) void'(line_buf.pop_back());
            end
         endcase
         send_line();
         if ($urandom_range(0, 19) == 0) send_power_down();
      end
      calm_stretch = 1'b0;
   endtask

   // ------------------------------------------------------------------------------------------
   // Sequence of the run.
   // ------------------------------------------------------------------------------------------

   initial begin
      forget_line();
      shown_view      = '0;
      shown_best      = '0;
      shown_vendor    = VENDOR_UNKNOWN;
      vendors_reached = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_power_down_and_extremes();
      test_gsv_fields();
      test_banner_and_vendor();
      test_short_lines_and_nul();
      test_overlong_line();
      test_random_traffic();

      req_valid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      // The run waits on a while, so that any stray result word after the last one is caught.
      repeat (10) @(posedge clock);

      $display("Sent %0d words: %0d lines judged, %0d GSV lines committed, %0d power-downs.",
               words_sent, lines_judged, gsv_commits, clears_sent);
      $display("Vendor codes shown during the run (one bit per code): %b.",
               vendors_reached[4:0]);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
